### hw/rtl/mwpk_pkg.sv
// Shared types and constants for the masked word pattern key generator.
package mwpk_pkg;

    localparam int NUM_POS              = 15;
    localparam int KEY_BYTES            = 7;
    localparam int POS_W                = 4;
    localparam int MAX_WORD_LETTERS_DEF = 15;
    localparam int RACK_SIZE_DEF        = 7;

    typedef logic [NUM_POS-1:0][7:0]       t_letters;
    typedef logic [NUM_POS-1:0]            t_pos_mask;
    typedef logic [NUM_POS-1:0][NUM_POS-1:0] t_order;
    typedef logic [NUM_POS-1:0][POS_W-1:0] t_ranks;

    typedef struct packed {
        logic        valid_res;
        t_pos_mask   fixed_pos;
        logic [3:0]  pattern_length;
        t_letters    fixed;
        t_pos_mask   rack;
        t_letters    letters;
        t_order      precedes;
        logic [31:0] tag;
    } t_s1;

    typedef struct packed {
        logic        valid_res;
        t_pos_mask   fixed_pos;
        logic [3:0]  pattern_length;
        t_letters    fixed;
        t_pos_mask   rack;
        t_letters    letters;
        t_ranks      rank;
        logic [31:0] tag;
    } t_s2;

    typedef struct packed {
        logic                   valid_res;
        t_pos_mask              fixed_pos;
        logic [3:0]             pattern_length;
        t_letters               fixed;
        logic [KEY_BYTES*8-1:0] rack_key;
        logic [31:0]            tag;
    } t_res;

endpackage

### hw/rtl/mwpk_mask_stage.sv
// Stage one: length and rack masks, validity and pairwise letter order.
module mwpk_mask_stage import mwpk_pkg::*; #(
    parameter int MAX_WORD_LETTERS = MAX_WORD_LETTERS_DEF,
    parameter int RACK_SIZE        = RACK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_letters_low,
    input  logic [55:0] i_letters_high,
    input  logic [3:0]  i_word_length,
    input  logic [14:0] i_rack_mask,
    input  logic [31:0] i_word_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output t_s1         o_data
);

    logic      r_valid;
    t_s1       r_data;
    t_s1       n_data;
    t_letters  letters;
    t_pos_mask active;
    t_pos_mask rack;
    logic [POS_W-1:0] count;

    assign letters = t_letters'({i_letters_high, i_letters_low});
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int i = 0; i < NUM_POS; i++) begin
            active[i] = POS_W'(i) < i_word_length;
        end
        rack  = i_rack_mask & active;
        count = POS_W'($countones(rack));

        n_data.valid_res      = (i_word_length != '0) &&
                                (int'(i_word_length) <= MAX_WORD_LETTERS) &&
                                (count != '0) && (int'(count) <= RACK_SIZE);
        n_data.fixed_pos      = active & ~rack;
        n_data.pattern_length = i_word_length;
        n_data.rack           = rack;
        n_data.letters        = letters;
        n_data.tag            = i_word_tag;
        for (int i = 0; i < NUM_POS; i++) begin
            n_data.fixed[i] = n_data.fixed_pos[i] ? letters[i] : 8'h00;
            for (int j = 0; j < NUM_POS; j++) begin
                n_data.precedes[i][j] = rack[j] && (j != i) &&
                                        ((letters[j] < letters[i]) ||
                                         ((letters[j] == letters[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/mwpk_rank_stage.sv
// Stage two: sorted rank of each rack letter.
module mwpk_rank_stage import mwpk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_data
);

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.valid_res      = i_data.valid_res;
        n_data.fixed_pos      = i_data.fixed_pos;
        n_data.pattern_length = i_data.pattern_length;
        n_data.fixed          = i_data.fixed;
        n_data.rack           = i_data.rack;
        n_data.letters        = i_data.letters;
        n_data.tag            = i_data.tag;
        for (int i = 0; i < NUM_POS; i++) begin
            n_data.rank[i] = POS_W'($countones(i_data.precedes[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/mwpk_key_stage.sv
// Stage three: scatter rack letters into the key and register the result.
module mwpk_key_stage import mwpk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_data
);

    logic r_valid;
    t_res r_data;
    t_res n_data;
    logic [KEY_BYTES*8-1:0] key;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        key = '0;
        for (int k = 0; k < KEY_BYTES; k++) begin
            for (int i = 0; i < NUM_POS; i++) begin
                if (i_data.rack[i] && (i_data.rank[i] == POS_W'(k))) begin
                    key[k*8 +: 8] = key[k*8 +: 8] | i_data.letters[i];
                end
            end
        end
        n_data.valid_res      = i_data.valid_res;
        n_data.tag            = i_data.tag;
        n_data.fixed_pos      = i_data.valid_res ? i_data.fixed_pos : '0;
        n_data.pattern_length = i_data.valid_res ? i_data.pattern_length : '0;
        n_data.fixed          = i_data.valid_res ? i_data.fixed : '0;
        n_data.rack_key       = i_data.valid_res ? key : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/masked_word_pattern_key_gen.sv
// Top level of the masked word pattern key generator.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_ready      letters, length, rack mask, tag
//   output    out        o_out_valid / i_out_ready    valid flag, fixed mask, length, fixed letters, key, tag
//
// One beat enters per cycle while o_in_ready is high; each result passes through the mask,
// rank and key register stages in that order before it leaves.
// Each stage takes a beat when it is empty or its successor advances, so a stall
// at the output fills bubbles before it reaches the input.
// Reset clears the stage valid bits only; payload registers are left as they are.
module masked_word_pattern_key_gen import mwpk_pkg::*; #(
    parameter int MAX_WORD_LETTERS = MAX_WORD_LETTERS_DEF,
    parameter int RACK_SIZE        = RACK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_letters_low,
    input  logic [55:0] i_letters_high,
    input  logic [3:0]  i_word_length,
    input  logic [14:0] i_rack_mask,
    input  logic [31:0] i_word_tag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_valid_res,
    output logic [14:0] o_fixed_mask,
    output logic [3:0]  o_pattern_length,
    output logic [63:0] o_fixed_low,
    output logic [55:0] o_fixed_high,
    output logic [55:0] o_rack_key,
    output logic [31:0] o_tag_out
);

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;
    t_res res;

    mwpk_mask_stage #(
        .MAX_WORD_LETTERS (MAX_WORD_LETTERS),
        .RACK_SIZE        (RACK_SIZE)
    ) u_mask (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_letters_low  (i_letters_low),
        .i_letters_high (i_letters_high),
        .i_word_length  (i_word_length),
        .i_rack_mask    (i_rack_mask),
        .i_word_tag     (i_word_tag),
        .o_valid        (s1_valid),
        .i_ready        (s1_ready),
        .o_data         (s1_data)
    );

    mwpk_rank_stage u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    mwpk_key_stage u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (res)
    );

    assign o_valid_res      = res.valid_res;
    assign o_fixed_mask     = res.fixed_pos;
    assign o_pattern_length = res.pattern_length;
    assign o_fixed_low      = res.fixed[7:0];
    assign o_fixed_high     = res.fixed[14:8];
    assign o_rack_key       = res.rack_key;
    assign o_tag_out        = res.tag;

endmodule

### hw/rtl/mwpk_checker.sv
// Port-level checks for the masked word pattern key generator, with its bind.
module mwpk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_valid_res,
    input logic [14:0] o_fixed_mask,
    input logic [3:0]  o_pattern_length,
    input logic [63:0] o_fixed_low,
    input logic [55:0] o_fixed_high,
    input logic [55:0] o_rack_key,
    input logic [31:0] o_tag_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tag_out) &&
            $stable(o_rack_key) && $stable(o_fixed_low) && $stable(o_valid_res))
        else $error("stalled output beat changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while pipeline output is empty");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_fixed_mask == '0 && o_pattern_length == '0 &&
            o_fixed_low == '0 && o_fixed_high == '0 && o_rack_key == '0)
        else $error("invalid result carries nonzero fields");

    a_mask_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> o_pattern_length != '0 &&
            (o_fixed_mask >> o_pattern_length) == '0)
        else $error("fixed mask reaches beyond the word length");

endmodule

bind masked_word_pattern_key_gen mwpk_checker u_mwpk_checker (.*);

### test/masked_word_pattern_key_gen_test.sv
// Testbench for masked_word_pattern_key_gen: directed and random words checked against a predictor.
module masked_word_pattern_key_gen_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mwpk_pkg::*;

    localparam int NUM_WORDS      = 950;
    localparam int GAP_MAX        = 12;
    localparam int HOLD_OFF_BEAT  = 400;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [63:0] letters_low;
        logic [55:0] letters_high;
        logic [3:0]  letter_count;
        logic [14:0] rack_mask;
        logic [31:0] word_tag;
    } t_word_beat;

    typedef struct {
        logic        valid_res;
        logic [14:0] fixed_pos;
        logic [3:0]  pattern_length;
        logic [63:0] fixed_low;
        logic [55:0] fixed_high;
        logic [55:0] rack_key;
        logic [31:0] tag_out;
    } t_pattern;

    class pattern_board;
        t_pattern pending_patterns[$];
        int       failures;

        function new();
            failures = 0;
        endfunction

        function t_pattern form_pattern(t_word_beat w);
            t_pattern     p;
            logic [14:0]  active;
            logic [14:0]  rack;
            logic [119:0] word_bytes;
            logic [119:0] fixed_bytes;
            logic [7:0]   ranked[16];
            logic [7:0]   c;
            int           len;
            int           count;
            int           n;
            int           at;

            p = '{default: '0};
            p.tag_out = w.word_tag;
            len = int'(w.letter_count);
            active = (len >= 1) ? 15'((16'd1 << len) - 16'd1) : 15'd0;
            rack = w.rack_mask & active;
            count = $countones(rack);
            if (len < 1 || len > MAX_WORD_LETTERS_DEF || count < 1 || count > RACK_SIZE_DEF)
                return p;

            word_bytes = {w.letters_high, w.letters_low};
            fixed_bytes = '0;
            n = 0;
            for (int i = 0; i < len; i++) begin
                c = word_bytes[8*i +: 8];
                if (!rack[i]) begin
                    fixed_bytes[8*i +: 8] = c;
                end else begin
                    at = n;
                    while (at > 0 && ranked[at-1] > c) begin
                        ranked[at] = ranked[at-1];
                        at--;
                    end
                    ranked[at] = c;
                    n++;
                end
            end
            p.valid_res      = 1'b1;
            p.fixed_pos      = active & ~rack;
            p.pattern_length = w.letter_count;
            p.fixed_low      = fixed_bytes[63:0];
            p.fixed_high     = fixed_bytes[119:64];
            for (int i = 0; i < n && i < KEY_BYTES; i++)
                p.rack_key[8*i +: 8] = ranked[i];
            return p;
        endfunction

        function void note_word(t_word_beat w);
            pending_patterns = {pending_patterns, form_pattern(w)};
        endfunction

        function void match_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
            end
        endfunction

        function void check_result(t_pattern got);
            t_pattern want;
            if (pending_patterns.size() == 0) begin
                failures++;
                $display("%0t: unexpected result beat, actual tag %h", $time, got.tag_out);
                return;
            end
            want = pending_patterns.pop_front();
            match_field("valid_res", 64'(want.valid_res), 64'(got.valid_res));
            match_field("fixed positions", 64'(want.fixed_pos), 64'(got.fixed_pos));
            match_field("pattern_length", 64'(want.pattern_length), 64'(got.pattern_length));
            match_field("fixed_low", want.fixed_low, got.fixed_low);
            match_field("fixed_high", 64'(want.fixed_high), 64'(got.fixed_high));
            match_field("rack_key", 64'(want.rack_key), 64'(got.rack_key));
            match_field("tag_out", 64'(want.tag_out), 64'(got.tag_out));
        endfunction

        function int pending_count();
            return pending_patterns.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_letters_low = '0;
    logic [55:0] i_letters_high = '0;
    logic [3:0]  i_word_length = '0;
    logic [14:0] i_rack_mask = '0;
    logic [31:0] i_word_tag = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_valid_res;
    logic [14:0] o_fixed_mask;
    logic [3:0]  o_pattern_length;
    logic [63:0] o_fixed_low;
    logic [55:0] o_fixed_high;
    logic [55:0] o_rack_key;
    logic [31:0] o_tag_out;

    pattern_board board;
    bit           sender_burst = 1'b0;
    bit           receiver_burst = 1'b0;
    int           idle_cycles = 0;

    masked_word_pattern_key_gen i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_letters_low    (i_letters_low),
        .i_letters_high   (i_letters_high),
        .i_word_length    (i_word_length),
        .i_rack_mask      (i_rack_mask),
        .i_word_tag       (i_word_tag),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_valid_res      (o_valid_res),
        .o_fixed_mask     (o_fixed_mask),
        .o_pattern_length (o_pattern_length),
        .o_fixed_low      (o_fixed_low),
        .o_fixed_high     (o_fixed_high),
        .o_rack_key       (o_rack_key),
        .o_tag_out        (o_tag_out)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic t_word_beat make_word(logic [63:0] lo, logic [55:0] hi, int len,
                                             logic [14:0] mask, logic [31:0] tag);
        t_word_beat w;
        w.letters_low  = lo;
        w.letters_high = hi;
        w.letter_count = 4'(len);
        w.rack_mask    = mask;
        w.word_tag     = tag;
        return w;
    endfunction

    function automatic t_word_beat random_word();
        t_word_beat   w;
        logic [119:0] bytes;
        logic [14:0]  active;
        int           len;
        int           want;
        bit           narrow;

        narrow = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < 15; i++)
            bytes[8*i +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom);
        w.letters_low  = bytes[63:0];
        w.letters_high = bytes[119:64];
        w.word_tag     = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            w.letter_count = 4'($urandom);
            w.rack_mask    = 15'($urandom);
        end else begin
            len = $urandom_range(1, 15);
            active = 15'((16'd1 << len) - 16'd1);
            want = $urandom_range(1, (len < RACK_SIZE_DEF) ? len : RACK_SIZE_DEF);
            w.letter_count = 4'(len);
            w.rack_mask = '0;
            while ($countones(w.rack_mask) < want)
                w.rack_mask[$urandom_range(0, len - 1)] = 1'b1;
            if ($urandom_range(0, 3) == 0)
                w.rack_mask |= 15'($urandom) & ~active;
        end
        return w;
    endfunction

    task automatic send_word(t_word_beat w);
        int gap;
        if ($urandom_range(0, 49) == 0)
            sender_burst = ~sender_burst;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_letters_low  <= w.letters_low;
        i_letters_high <= w.letters_high;
        i_word_length  <= w.letter_count;
        i_rack_mask    <= w.rack_mask;
        i_word_tag     <= w.word_tag;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_word(w);
    endtask

    task automatic take_results();
        t_pattern got;
        int       gap;
        int       taken;
        taken = 0;
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_burst = ~receiver_burst;
            gap = (taken == HOLD_OFF_BEAT) ? HOLD_OFF_LEN : draw_gap(receiver_burst);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
            got.valid_res      = o_valid_res;
            got.fixed_pos      = o_fixed_mask;
            got.pattern_length = o_pattern_length;
            got.fixed_low      = o_fixed_low;
            got.fixed_high     = o_fixed_high;
            got.rack_key       = o_rack_key;
            got.tag_out        = o_tag_out;
            board.check_result(got);
            taken++;
        end
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        take_results();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("masked_word_pattern_key_gen verification failed");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_word(64'h1122334455667788, 56'h99AABBCCDDEEFF, 0, 15'h7FFF, 32'h0));
        send_word(make_word(64'h0000000000000041, 56'h0, 1, 15'h0001, 32'hFFFFFFFF));
        send_word(make_word(64'h0000000000000041, 56'h0, 1, 15'h0000, 32'h1));
        send_word(make_word(64'hFFFFFFFFFFFFFFFF, 56'hFFFFFFFFFFFFFF, 15, 15'h007F, 32'h2));
        send_word(make_word(64'hFFFFFFFFFFFFFFFF, 56'hFFFFFFFFFFFFFF, 15, 15'h00FF, 32'h3));
        send_word(make_word(64'hFFFFFFFFFFFFFFFF, 56'hFFFFFFFFFFFFFF, 15, 15'h7FFF, 32'h4));
        send_word(make_word(64'hA5A5A5A5A5A5A5A5, 56'h5A5A5A5A5A5A5A, 4, 15'h7FF1, 32'h5));
        send_word(make_word(64'hFFFFFFFFFFFFFFFF, 56'hFFFFFFFFFFFFFF, 15, 15'h7F00, 32'h6));
        send_word(make_word(64'h0, 56'h0, 7, 15'h007F, 32'h7));
        send_word(make_word(64'h0102030405060708, 56'h0, 8, 15'h00FE, 32'h8));
        send_word(make_word(64'h6161626263636464, 56'h65, 9, 15'h01AA, 32'h9));
        send_word(make_word(64'h1111111111111111, 56'h22222222222280, 15, 15'h4000, 32'hA));
        send_word(make_word(64'h8000000000000000, 56'h7F, 8, 15'h0080, 32'hB));
        send_word(make_word(64'h00000000000000FF, 56'hFE, 9, 15'h0100, 32'hC));
        send_word(make_word(64'h7A79787776757473, 56'h72717069686766, 15, 15'h5555, 32'hD));
        send_word(make_word(64'h7A79787776757473, 56'h72717069686766, 15, 15'h2AAA, 32'hE));
        send_word(make_word(64'hDEADBEEFCAFEF00D, 56'h0, 2, 15'h7FFE, 32'h80000000));

        for (int n = 0; n < NUM_WORDS; n++)
            send_word(random_word());
        i_in_valid <= 1'b0;

        while (board.pending_count() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0 && board.pending_count() == 0) begin
            $display("masked_word_pattern_key_gen verification clean");
        end else begin
            $display("masked_word_pattern_key_gen verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/mwpk_pkg.sv
hw/rtl/mwpk_mask_stage.sv
hw/rtl/mwpk_rank_stage.sv
hw/rtl/mwpk_key_stage.sv
hw/rtl/masked_word_pattern_key_gen.sv
hw/rtl/mwpk_checker.sv
test/masked_word_pattern_key_gen_test.sv
